// ===== rtl/core/ising_metropolis_spin_update_unit_defines.svh =====
// assertion macros for the ising metropolis spin update unit
// used by the top level only, no other dependencies
`ifndef ISING_METROPOLIS_SPIN_UPDATE_UNIT_DEFINES_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ISMU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ismu assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define ISMU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ismu assertion failed");

`endif

// ===== rtl/core/ismu_pkg.sv =====
// shared constants, types and index helpers for the spin update unit
// no dependencies
package ismu_pkg;

  localparam int LATTICE_SIDE = 64;
  localparam int IDX_W        = $clog2(LATTICE_SIDE);
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int COORD_W      = 6;
  localparam int COORD_SPAN   = 1 << COORD_W;
  localparam int RND_W        = 16;
  localparam int LEVEL_W      = 16;
  localparam int MAG_W        = 14;
  localparam int TOTAL_RAW_W  = $clog2(SITE_COUNT) + 2;
  localparam int TOTAL_W      = (TOTAL_RAW_W > MAG_W) ? TOTAL_RAW_W : MAG_W;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_LEVEL_FOUR  = 1'b0;
  localparam logic REG_LEVEL_EIGHT = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_FOUR_RESET  = LEVEL_W'(1200);
  localparam logic [LEVEL_W-1:0] LEVEL_EIGHT_RESET = LEVEL_W'(22);

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [LATTICE_SIDE-1:0] row_t;

  typedef struct packed {
    logic en;
    logic we;
    idx_t addr;
    row_t wdata;
  } ram_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_four;
    logic [LEVEL_W-1:0] level_eight;
  } cfg_t;

  typedef struct packed {
    logic new_spin;
    logic flipped;
  } eval_res_t;

  // coordinate modulo the lattice side, as a small constant table
  function automatic idx_t wrap_coord(input logic [COORD_W-1:0] v);
    idx_t r;
    r = '0;
    for (int i = 0; i < COORD_SPAN; i++) begin
      if (v == COORD_W'(i)) begin
        r = IDX_W'(i % LATTICE_SIDE);
      end
    end
    return r;
  endfunction

  function automatic idx_t next_idx(input idx_t i);
    return (i == IDX_W'(LATTICE_SIDE - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic idx_t prev_idx(input idx_t i);
    return (i == '0) ? IDX_W'(LATTICE_SIDE - 1) : i - IDX_W'(1);
  endfunction

endpackage

// ===== rtl/core/ismu_row_ram.sv =====
// single-port lattice memory, one row of spins per entry
// depends on ismu_pkg
module ismu_row_ram (
  input  logic               clk,
  input  ismu_pkg::ram_req_t req,
  output ismu_pkg::row_t     rdata
);
  import ismu_pkg::*;

  row_t mem [LATTICE_SIDE];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ===== rtl/core/ismu_cfg_regs.sv =====
// apb-style register port holding the two acceptance thresholds
// depends on ismu_pkg
module ismu_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ismu_pkg::PADDR_W-1:0] paddr,
  input  logic [ismu_pkg::PDATA_W-1:0] pwdata,
  output logic [ismu_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output ismu_pkg::cfg_t               cfg
);
  import ismu_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_four  <= LEVEL_FOUR_RESET;
      cfg.level_eight <= LEVEL_EIGHT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LEVEL_FOUR:  cfg.level_four  <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_EIGHT: cfg.level_eight <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LEVEL_FOUR:  prdata = {{(PDATA_W-LEVEL_W){1'b0}}, cfg.level_four};
      REG_LEVEL_EIGHT: prdata = {{(PDATA_W-LEVEL_W){1'b0}}, cfg.level_eight};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ismu_site_eval.sv =====
// metropolis decision for one site from its three lattice rows
// depends on ismu_pkg
module ismu_site_eval (
  input  logic                       op,
  input  logic                       spin_value,
  input  logic [ismu_pkg::RND_W-1:0] random_value,
  input  ismu_pkg::idx_t             col,
  input  ismu_pkg::idx_t             col_left,
  input  ismu_pkg::idx_t             col_right,
  input  ismu_pkg::row_t             row_up,
  input  ismu_pkg::row_t             row_mid,
  input  ismu_pkg::row_t             row_dn,
  input  ismu_pkg::cfg_t             cfg,
  output ismu_pkg::eval_res_t        res
);
  import ismu_pkg::*;

  logic       old_spin;
  logic [3:0] aligned;
  logic [2:0] aligned_cnt;
  logic       flip;

  assign old_spin = row_mid[col];

  // neighbours with the same sign as the site
  assign aligned = ~({row_mid[col_right], row_mid[col_left], row_up[col], row_dn[col]}
                     ^ {4{old_spin}});
  assign aligned_cnt = {2'b00, aligned[0]} + {2'b00, aligned[1]}
                     + {2'b00, aligned[2]} + {2'b00, aligned[3]};

  // two or fewer aligned means the energy does not rise
  always_comb begin
    case (aligned_cnt)
      3'd3:    flip = (random_value <= cfg.level_four);
      3'd4:    flip = (random_value <= cfg.level_eight);
      default: flip = 1'b1;
    endcase
  end

  always_comb begin
    if (op == OP_UPDATE) begin
      res.flipped  = flip;
      res.new_spin = old_spin ^ flip;
    end else begin
      res.flipped  = 1'b0;
      res.new_spin = spin_value;
    end
  end

endmodule

// ===== rtl/core/ising_metropolis_spin_update_unit.sv =====
// Ising lattice unit: 64x64 spins with wraparound in a single-port row memory, one
// result strobe per item. After reset a clearing pass writes one row per cycle,
// setting every spin to +1, with busy high; register writes are taken during it.
// An item is taken when start is high and busy is low. An update reads the rows at,
// above and below the site, then writes the row back on the same memory port; a load
// does one read and one write. busy drops in the write-back cycle, so the next item
// can be taken there. Each result shows on the output ports for one cycle with done
// high, the cycle after the write-back; the receiver cannot stall it.
// Depends on ismu_pkg, ismu_row_ram, ismu_cfg_regs, ismu_site_eval and the defines header.
`include "ising_metropolis_spin_update_unit_defines.svh"

module ising_metropolis_spin_update_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [ismu_pkg::COORD_W-1:0]        x_coord,
  input  logic [ismu_pkg::COORD_W-1:0]        y_coord,
  input  logic                                spin_value,
  input  logic [ismu_pkg::RND_W-1:0]          random_value,
  output logic                                done,
  output logic                                spin_now,
  output logic                                flipped,
  output logic signed [ismu_pkg::MAG_W-1:0]   magnetization,
  output logic                                fully_ordered,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ismu_pkg::PADDR_W-1:0]        paddr,
  input  logic [ismu_pkg::PDATA_W-1:0]        pwdata,
  output logic [ismu_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import ismu_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RD_MID = 3'd2;
  localparam logic [2:0] ST_RD_UP  = 3'd3;
  localparam logic [2:0] ST_RD_DN  = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;

  localparam idx_t LAST_ROW = IDX_W'(LATTICE_SIDE - 1);
  localparam logic signed [TOTAL_W-1:0] FULL_POS = TOTAL_W'(SITE_COUNT);
  localparam logic signed [TOTAL_W-1:0] FULL_NEG = TOTAL_W'(-SITE_COUNT);

  logic [2:0] state, state_next;
  idx_t       clr_row;
  logic       accept;

  // item held for the duration of its work
  logic             item_op;
  logic             item_spin;
  logic [RND_W-1:0] item_rnd;
  idx_t             item_col, item_col_l, item_col_r;
  idx_t             item_row, item_row_up, item_row_dn;

  row_t row_mid_buf, row_up_buf;
  row_t rd_data, row_mid_now, row_wr;

  logic signed [TOTAL_W-1:0] spin_total, spin_total_next;

  ram_req_t  ram_req;
  cfg_t      cfg;
  eval_res_t eval_res;

  ismu_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ismu_row_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rd_data)
  );

  // a load reaches the write-back straight after its one read
  assign row_mid_now = (item_op == OP_UPDATE) ? row_mid_buf : rd_data;

  ismu_site_eval u_eval (
    .op           (item_op),
    .spin_value   (item_spin),
    .random_value (item_rnd),
    .col          (item_col),
    .col_left     (item_col_l),
    .col_right    (item_col_r),
    .row_up       (row_up_buf),
    .row_mid      (row_mid_now),
    .row_dn       (rd_data),
    .cfg          (cfg),
    .res          (eval_res)
  );

  assign busy   = (state != ST_IDLE) && (state != ST_WRITE);
  assign accept = start && !busy;

  always_comb begin
    row_wr           = row_mid_now;
    row_wr[item_col] = eval_res.new_spin;
  end

  always_comb begin
    ram_req.en    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.addr  = item_row;
    ram_req.wdata = row_wr;
    case (state)
      ST_CLEAR: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_row;
        ram_req.wdata = '1;
      end
      ST_RD_MID: begin
        ram_req.en = 1'b1;
      end
      ST_RD_UP: begin
        ram_req.en   = 1'b1;
        ram_req.addr = item_row_up;
      end
      ST_RD_DN: begin
        ram_req.en   = 1'b1;
        ram_req.addr = item_row_dn;
      end
      ST_WRITE: begin
        ram_req.en = 1'b1;
        ram_req.we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  state_next = (clr_row == LAST_ROW) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = accept ? ST_RD_MID : ST_IDLE;
      ST_RD_MID: state_next = (item_op == OP_UPDATE) ? ST_RD_UP : ST_WRITE;
      ST_RD_UP:  state_next = ST_RD_DN;
      ST_RD_DN:  state_next = ST_WRITE;
      ST_WRITE:  state_next = accept ? ST_RD_MID : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // total moves by two whenever the site changes sign
  always_comb begin
    spin_total_next = spin_total;
    if (eval_res.new_spin != row_mid_now[item_col]) begin
      spin_total_next = eval_res.new_spin ? spin_total + TOTAL_W'(2)
                                          : spin_total - TOTAL_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_row    <= '0;
      spin_total <= FULL_POS;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_WRITE);
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + IDX_W'(1);
      end
      if (state == ST_WRITE) begin
        spin_total <= spin_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op     <= op;
      item_spin   <= spin_value;
      item_rnd    <= random_value;
      item_col    <= wrap_coord(x_coord);
      item_col_l  <= prev_idx(wrap_coord(x_coord));
      item_col_r  <= next_idx(wrap_coord(x_coord));
      item_row    <= wrap_coord(y_coord);
      item_row_up <= prev_idx(wrap_coord(y_coord));
      item_row_dn <= next_idx(wrap_coord(y_coord));
    end
    if (state == ST_RD_UP) begin
      row_mid_buf <= rd_data;
    end
    if (state == ST_RD_DN) begin
      row_up_buf <= rd_data;
    end
    if (state == ST_WRITE) begin
      spin_now      <= eval_res.new_spin;
      flipped       <= eval_res.flipped;
      magnetization <= spin_total_next[MAG_W-1:0];
      fully_ordered <= (spin_total_next == FULL_POS) || (spin_total_next == FULL_NEG);
    end
  end

  `ISMU_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ISMU_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ISMU_ASSERT_IMPLIES(a_ram_we_state, clk, rst, ram_req.we, state == ST_WRITE || state == ST_CLEAR)
  `ISMU_ASSERT_IMPLIES(a_done_after_write, clk, rst, done, $past(state) == ST_WRITE)

endmodule

// ===== dv/tb_ising_metropolis_spin_update_unit.sv =====
// testbench for the ising metropolis spin update unit: directed stimulus table, then random
// site loads and updates checked against a lattice predictor; depends on ismu_pkg and the rtl
`timescale 1ns / 1ps

module tb_ising_metropolis_spin_update_unit;
  import ismu_pkg::*;

  typedef struct packed {
    logic                    spin;
    logic                    flip;
    logic signed [MAG_W-1:0] mag;
    logic                    ordered;
  } site_result_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               sv;
    logic [RND_W-1:0]   rnd;
    logic               pinned;
    site_result_t       want;
  } stim_row_t;

  localparam int STIM_ROWS = 20;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       op = OP_LOAD;
  logic [COORD_W-1:0]         x_coord = '0;
  logic [COORD_W-1:0]         y_coord = '0;
  logic                       spin_value = 1'b0;
  logic [RND_W-1:0]           random_value = '0;
  logic                       done;
  logic                       spin_now;
  logic                       flipped;
  logic signed [MAG_W-1:0]    magnetization;
  logic                       fully_ordered;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  // lattice predictor state
  bit [SITE_COUNT-1:0] spin_grid;
  int                  spin_sum;
  logic [LEVEL_W-1:0]  level_four_q;
  logic [LEVEL_W-1:0]  level_eight_q;

  site_result_t pending_results [$];
  int err_count;
  int load_count;
  int update_count;
  int flip_count;
  int level_settings;
  int mag_low;
  int mag_high;

  // rows with a pinned result start from the all +1 lattice at reset thresholds
  stim_row_t stim_rows [STIM_ROWS] = '{
    '{OP_UPDATE, 6'd0,  6'd0,  1'b0, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 14'sd4096, 1'b1}},
    '{OP_UPDATE, 6'd63, 6'd63, 1'b1, 16'h0000, 1'b1, '{1'b0, 1'b1, 14'sd4094, 1'b0}},
    '{OP_LOAD,   6'd63, 6'd63, 1'b1, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 14'sd4096, 1'b1}},
    '{OP_LOAD,   6'd0,  6'd0,  1'b0, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 14'sd4094, 1'b0}},
    '{OP_UPDATE, 6'd0,  6'd0,  1'b1, 16'hFFFF, 1'b1, '{1'b1, 1'b1, 14'sd4096, 1'b1}},
    '{OP_LOAD,   6'd63, 6'd0,  1'b0, 16'h0000, 1'b1, '{1'b0, 1'b0, 14'sd4094, 1'b0}},
    // energy rise of four, random value just above and at the threshold
    '{OP_UPDATE, 6'd0,  6'd0,  1'b0, 16'd1201, 1'b0, '0},
    '{OP_UPDATE, 6'd0,  6'd0,  1'b1, 16'd1200, 1'b0, '0},
    // energy drop of four across the column wrap
    '{OP_UPDATE, 6'd63, 6'd0,  1'b0, 16'hFFFF, 1'b0, '0},
    '{OP_LOAD,   6'd1,  6'd63, 1'b0, 16'h5A5A, 1'b0, '0},
    // zero energy change, flips both ways
    '{OP_UPDATE, 6'd0,  6'd63, 1'b0, 16'hFFFF, 1'b0, '0},
    '{OP_UPDATE, 6'd0,  6'd63, 1'b1, 16'hFFFF, 1'b0, '0},
    // energy rise of eight around the threshold
    '{OP_UPDATE, 6'd40, 6'd20, 1'b0, 16'd23,   1'b0, '0},
    '{OP_UPDATE, 6'd40, 6'd20, 1'b1, 16'd22,   1'b0, '0},
    '{OP_UPDATE, 6'd40, 6'd20, 1'b0, 16'hFFFF, 1'b0, '0},
    '{OP_LOAD,   6'd40, 6'd20, 1'b1, 16'hA5C3, 1'b0, '0},
    '{OP_UPDATE, 6'd31, 6'd32, 1'b1, 16'h0000, 1'b0, '0},
    '{OP_LOAD,   6'd31, 6'd32, 1'b1, 16'hFFFF, 1'b0, '0},
    '{OP_LOAD,   6'd1,  6'd63, 1'b1, 16'h0000, 1'b0, '0},
    '{OP_LOAD,   6'd0,  6'd0,  1'b1, 16'h0000, 1'b1, '{1'b1, 1'b0, 14'sd4096, 1'b1}}
  };

  ising_metropolis_spin_update_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .spin_value    (spin_value),
    .random_value  (random_value),
    .done          (done),
    .spin_now      (spin_now),
    .flipped       (flipped),
    .magnetization (magnetization),
    .fully_ordered (fully_ordered),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #500_000;
    $display("status: fail");
    $finish;
  end

  function automatic int spin_at(input int col, input int row);
    return spin_grid[row * LATTICE_SIDE + col] ? 1 : -1;
  endfunction

  // applies one item to the lattice copy and returns the site's new state
  function automatic site_result_t step_lattice(input logic op_i, input logic [COORD_W-1:0] xc,
                                                input logic [COORD_W-1:0] yc, input logic sv,
                                                input logic [RND_W-1:0] rnd);
    int col;
    int row;
    int idx;
    int old_spin;
    int nsum;
    int delta;
    logic flip;
    site_result_t r;
    col = int'(xc) % LATTICE_SIDE;
    row = int'(yc) % LATTICE_SIDE;
    idx = row * LATTICE_SIDE + col;
    old_spin = spin_grid[idx] ? 1 : -1;
    flip = 1'b0;
    if (op_i == OP_LOAD) begin
      spin_sum += (sv ? 1 : -1) - old_spin;
      spin_grid[idx] = sv;
    end else begin
      nsum = spin_at((col + 1) % LATTICE_SIDE, row)
           + spin_at((col + LATTICE_SIDE - 1) % LATTICE_SIDE, row)
           + spin_at(col, (row + 1) % LATTICE_SIDE)
           + spin_at(col, (row + LATTICE_SIDE - 1) % LATTICE_SIDE);
      delta = 2 * old_spin * nsum;
      if (delta <= 0) flip = 1'b1;
      else if (delta == 4) flip = (rnd <= level_four_q);
      else flip = (rnd <= level_eight_q);
      if (flip) begin
        spin_grid[idx] = ~spin_grid[idx];
        spin_sum -= 2 * old_spin;
      end
    end
    r.spin = spin_grid[idx];
    r.flip = flip;
    r.mag = MAG_W'(spin_sum);
    r.ordered = (spin_sum == SITE_COUNT) || (spin_sum == -SITE_COUNT);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endtask

  // called just after a rising edge; returns at the edge where the transfer happens
  task automatic issue(input logic op_i, input logic [COORD_W-1:0] xc,
                       input logic [COORD_W-1:0] yc, input logic sv,
                       input logic [RND_W-1:0] rnd, input logic pinned,
                       input site_result_t pinned_want);
    site_result_t want;
    start <= 1'b1;
    op <= op_i;
    x_coord <= xc;
    y_coord <= yc;
    spin_value <= sv;
    random_value <= rnd;
    do @(posedge clk); while (busy !== 1'b0);
    want = step_lattice(op_i, xc, yc, sv, rnd);
    if (pinned) want = pinned_want;
    pending_results.push_back(want);
    if (op_i == OP_LOAD) load_count++;
    else update_count++;
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write one threshold, then read it back in the next transfer
  task automatic write_level(input logic reg_sel, input logic [LEVEL_W-1:0] val);
    logic [PDATA_W-1:0] word;
    word = {16'($urandom), val};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_LEVEL_FOUR) level_four_q = val;
    else level_eight_q = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== PDATA_W'(val))
      report_mismatch($sformatf("level %0d read back %h, expected %h", reg_sel, prdata, val));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_levels(input logic [LEVEL_W-1:0] four, input logic [LEVEL_W-1:0] eight);
    write_level(REG_LEVEL_FOUR, four);
    write_level(REG_LEVEL_EIGHT, eight);
    level_settings++;
  endtask

  // mostly sites near the wrapped corner so neighbours interact
  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 9) < 3) return COORD_W'($urandom);
    return COORD_W'(($urandom_range(0, 3) + 62) % 64);
  endfunction

  function automatic logic [RND_W-1:0] pick_rand();
    int v;
    case ($urandom_range(0, 6))
      0: v = 0;
      1: v = 65535;
      2: v = int'(level_four_q) + int'($urandom_range(0, 2)) - 1;
      3: v = int'(level_eight_q) + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RND_W'(v);
  endfunction

  task automatic run_random(input int count, input bit gaps);
    bit gap_on;
    logic op_i;
    gap_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) gap_on = gaps && ($urandom_range(0, 3) != 0);
      op_i = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_UPDATE;
      issue(op_i, pick_coord(), pick_coord(), 1'($urandom), pick_rand(), 1'b0, '0);
      if (gap_on && $urandom_range(0, 2) == 0) idle_burst();
    end
  endtask

  always @(posedge clk) begin
    site_result_t got;
    site_result_t want;
    if (!rst && done === 1'b1) begin
      got = '{spin_now, flipped, magnetization, fully_ordered};
      if (got.flip === 1'b1) flip_count++;
      if (int'(got.mag) < mag_low) mag_low = int'(got.mag);
      if (int'(got.mag) > mag_high) mag_high = int'(got.mag);
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.spin !== want.spin || got.flip !== want.flip || got.mag !== want.mag ||
            got.ordered !== want.ordered)
          report_mismatch($sformatf(
            "spin %b/%b flipped %b/%b magnetization %0d/%0d ordered %b/%b (got/expected)",
            got.spin, want.spin, got.flip, want.flip, got.mag, want.mag,
            got.ordered, want.ordered));
      end
    end
  end

  initial begin
    logic [LEVEL_W-1:0] four_set [6];
    logic [LEVEL_W-1:0] eight_set [6];
    spin_grid = '1;
    spin_sum = SITE_COUNT;
    level_four_q = LEVEL_FOUR_RESET;
    level_eight_q = LEVEL_EIGHT_RESET;
    mag_low = SITE_COUNT;
    mag_high = SITE_COUNT;
    four_set = '{16'd0, 16'hFFFF, 16'($urandom), 16'hFFFF, 16'd0, 16'd1200};
    eight_set = '{16'd0, 16'hFFFF, 16'($urandom), 16'd0, 16'hFFFF, 16'd22};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < STIM_ROWS; i++) begin
      issue(stim_rows[i].op, stim_rows[i].x, stim_rows[i].y, stim_rows[i].sv,
            stim_rows[i].rnd, stim_rows[i].pinned, stim_rows[i].want);
      if (i % 3 == 1) idle_burst();
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      set_levels(four_set[p], eight_set[p]);
      run_random(70, 1'b1);
    end

    // back to back to the end
    run_random(80, 1'b0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d loads and %0d updates, %0d flips, %0d threshold settings",
             load_count, update_count, flip_count, level_settings);
    $display("magnetization seen from %0d to %0d, %0d mismatches",
             mag_low, mag_high, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ismu_pkg.sv
rtl/core/ismu_row_ram.sv
rtl/core/ismu_cfg_regs.sv
rtl/core/ismu_site_eval.sv
rtl/core/ising_metropolis_spin_update_unit.sv
dv/tb_ising_metropolis_spin_update_unit.sv
